// ----- sv/xae_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and character functions for the XML attribute escaper.
package xae_pkg;

    // Longest input string the length counter is sized for.
    localparam longint unsigned MAX_INPUT_BYTES = 65536;

    // Width of the output byte counter and its saturation point.
    localparam int COUNT_W = 19;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned CAP_RAW = 64'd6 * MAX_INPUT_BYTES + 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (CAP_RAW > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(CAP_RAW);

    // Queue between the classifier and the emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Position within one escaped run, terminator included (0..6).
    localparam int IDX_W = 3;

    // Special input bytes.
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;

    // How one input byte is rendered.
    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_LT,
        KIND_AMP,
        KIND_GT,
        KIND_APOS,
        KIND_QUOT,
        KIND_HEX
    } kind_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       eos;
    } desc_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Sorts one raw byte into its rendering kind.
    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        k = KIND_PASS;
        priority if (c == "<")
            k = KIND_LT;
        else if (c == "&")
            k = KIND_AMP;
        else if (c == ">")
            k = KIND_GT;
        else if (c == "'")
            k = KIND_APOS;
        else if (c == "\"")
            k = KIND_QUOT;
        else if ((c < CTRL_LIMIT && c != CHAR_TAB && c != CHAR_LF) || c == CHAR_DEL)
            k = KIND_HEX;
        else
            k = KIND_PASS;
        return k;
    endfunction

    // Number of bytes in the escaped run of one kind.
    function automatic logic [IDX_W-1:0] run_length(input kind_t k);
        logic [IDX_W-1:0] n;
        unique case (k)
            KIND_PASS: n = IDX_W'(1);
            KIND_LT:   n = IDX_W'(4);
            KIND_GT:   n = IDX_W'(4);
            KIND_AMP:  n = IDX_W'(5);
            KIND_APOS: n = IDX_W'(6);
            KIND_QUOT: n = IDX_W'(6);
            KIND_HEX:  n = IDX_W'(6);
            default:   n = IDX_W'(1);
        endcase
        return n;
    endfunction

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = 8'h30 + {4'h0, v};
        else
            d = 8'h61 + {4'h0, v} - 8'd10;
        return d;
    endfunction

    // Byte at position idx of the escaped run for data of kind k.
    function automatic logic [7:0] run_char(input kind_t k, input logic [7:0] data,
                                            input logic [IDX_W-1:0] idx);
        logic [47:0] s;
        logic [7:0]  b;
        unique case (k)
            KIND_PASS: s = {data, 40'h0};
            KIND_LT:   s = {"&lt;", 16'h0};
            KIND_GT:   s = {"&gt;", 16'h0};
            KIND_AMP:  s = {"&amp;", 8'h0};
            KIND_APOS: s = "&apos;";
            KIND_QUOT: s = "&quot;";
            KIND_HEX:  s = {"&#x", hex_digit(data[7:4]), hex_digit(data[3:0]), ";"};
            default:   s = 48'h0;
        endcase
        case (idx)
            3'd0:    b = s[47:40];
            3'd1:    b = s[39:32];
            3'd2:    b = s[31:24];
            3'd3:    b = s[23:16];
            3'd4:    b = s[15:8];
            3'd5:    b = s[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/xae_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input side: accepts raw byte beats and classifies them into queue entries.
module xae_front
    import xae_pkg::*;
(
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_string,
    input  wire queue_stat_t q_stat,
    output logic             push,
    output desc_t            push_desc
);

    // Hold off the source only while the queue is full.
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // Classify the byte on its way into the queue.
    always_comb
    begin
        push_desc.kind = classify(in_byte);
        push_desc.data = in_byte;
        push_desc.eos  = end_of_string;
    end

endmodule
`default_nettype wire

// ----- sv/xae_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Small show-ahead queue of classified items between the front and back ends.
module xae_queue
    import xae_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    input  wire logic  pop,
    output desc_t      head,
    output queue_stat_t stat
);

    desc_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_next;

    // Status and head of queue.
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule
`default_nettype wire

// ----- sv/xae_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Output side: walks each queued item through its escaped run and keeps the length count.
module xae_back
    import xae_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire desc_t             head,
    input  wire queue_stat_t       q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   last_of_run,
    output logic                   is_terminator,
    output logic [COUNT_W-1:0]     total_length
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic [7:0]           out_byte_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 term_reg;
    logic                 term_next;
    logic [COUNT_W-1:0]   length_reg;
    logic [COUNT_W-1:0]   length_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [IDX_W-1:0]     run_len;
    logic [COUNT_W-1:0]   count_bump;
    logic                 advance;
    logic                 emit;
    logic                 at_term;
    logic                 at_last_char;
    logic                 item_done;

    // Position of the head item within its run.
    assign run_len      = run_length(head.kind);
    assign at_term      = head.eos && (idx_reg == run_len);
    assign at_last_char = (idx_reg == run_len - 1'b1);
    assign item_done    = at_term || (at_last_char && !head.eos);
    assign count_bump   = (count_reg < COUNT_CAP) ? count_reg + 1'b1 : count_reg;

    // The output register takes a new beat when empty or being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign emit    = advance && !q_stat.empty;
    assign pop     = emit && item_done;

    // Next output beat, position and count.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        term_next      = term_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        if (advance)
            out_valid_next = !q_stat.empty;
        if (emit)
        begin
            out_byte_next = at_term ? 8'h00 : run_char(head.kind, head.data, idx_reg);
            last_next     = item_done;
            term_next     = at_term;
            length_next   = count_bump;
            count_next    = at_term ? '0 : count_bump;
            idx_next      = item_done ? '0 : idx_reg + 1'b1;
        end
    end

    // Control state and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        term_reg     <= term_next;
        length_reg   <= length_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_run   = last_reg;
    assign is_terminator = term_reg;
    assign total_length  = length_reg;

endmodule
`default_nettype wire

// ----- sv/xml_attribute_escaper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the XML attribute escaper: front classifier, item queue and run emitter.
//
// Each input beat carries one text byte and an end-of-string flag; the block emits
// the escaped form one byte per output beat: a plain byte gives one beat, an entity
// such as &lt; or &#x1f; gives four to six, and a flagged end adds a zero terminator
// beat that carries the total string length (saturating at 393217). The emitter
// produces one output beat per cycle while out_stall is low, so plain text then flows
// at one byte per cycle and an escaped byte stays at the queue head until its whole run
// is emitted; a four-entry queue between the classifier and the emitter lets input keep
// arriving while a run is emitted, and the input stalls only when that queue is full.
// Each accepted input byte passes through its queue entry and then the output register
// before its first output beat is presented.
module xml_attribute_escaper
    import xae_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         in_byte,
    input  wire logic               end_of_string,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic                    last_of_run,
    output logic                    is_terminator,
    output logic [COUNT_W-1:0]      total_length
);

    queue_stat_t q_stat;
    desc_t       push_desc;
    desc_t       head;
    logic        push;
    logic        pop;

    xae_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .q_stat        (q_stat),
        .push          (push),
        .push_desc     (push_desc)
    );

    xae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    xae_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .is_terminator (is_terminator),
        .total_length  (total_length)
    );

endmodule
`default_nettype wire

// ----- tb/sv/xae_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the XML attribute escaper: predicts escaped output beats and compares them.
module xae_checker
    import xae_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               end_of_string,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         out_byte,
    input  logic               last_of_run,
    input  logic               is_terminator,
    input  logic [COUNT_W-1:0] total_length,
    output int                 fail_count,
    output int                 pending,
    output int                 beats_in,
    output int                 beats_out,
    output int                 strings_done,
    output int                 stall_cycles,
    output int                 cap_hits
);

    localparam int REPORT_LIMIT = 10;

    // One escaped output beat as the block should present it.
    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic               term;
        logic [COUNT_W-1:0] len;
    } esc_beat_t;

    esc_beat_t          expected_beats[$];
    logic [COUNT_W-1:0] str_bytes = '0;

    initial
    begin
        fail_count   = 0;
        beats_in     = 0;
        beats_out    = 0;
        strings_done = 0;
        stall_cycles = 0;
        cap_hits     = 0;
    end

    assign pending = expected_beats.size();

    // Entity text for one source byte; an empty string means the byte passes through.
    function automatic string escaped_text(input logic [7:0] c);
        string s;
        s = "";
        case (c)
            "<":  s = "&lt;";
            "&":  s = "&amp;";
            ">":  s = "&gt;";
            "'":  s = "&apos;";
            "\"": s = "&quot;";
            default:
            begin
                if ((c < CTRL_LIMIT && c != CHAR_TAB && c != CHAR_LF) || c == CHAR_DEL)
                    s = $sformatf("&#x%02x;", c);
            end
        endcase
        return s;
    endfunction

    // Queue every output beat that one accepted source byte must produce.
    task automatic predict_escape(input logic [7:0] c, input logic eos);
        string     ent;
        int        n;
        esc_beat_t b;
        ent = escaped_text(c);
        n = (ent.len() == 0) ? 1 : ent.len();
        for (int k = 0; k < n; k++)
        begin
            if (str_bytes < COUNT_CAP)
                str_bytes = str_bytes + 1'b1;
            b.data = (ent.len() == 0) ? c : ent[k];
            b.last = (k == n - 1) && !eos;
            b.term = 1'b0;
            b.len  = str_bytes;
            expected_beats.push_back(b);
        end
        // The end flag adds a zero terminator carrying the whole length.
        if (eos)
        begin
            if (str_bytes < COUNT_CAP)
                str_bytes = str_bytes + 1'b1;
            b.data = 8'h00;
            b.last = 1'b1;
            b.term = 1'b1;
            b.len  = str_bytes;
            expected_beats.push_back(b);
            str_bytes = '0;
        end
    endtask

    // Compare one accepted output beat with the oldest prediction.
    task automatic compare_beat();
        esc_beat_t want;
        if (expected_beats.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("Unexpected output beat %0d: byte %02h last %b term %b len %0d",
                         beats_out, out_byte, last_of_run, is_terminator, total_length);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (want.data !== out_byte || want.last !== last_of_run ||
                want.term !== is_terminator || want.len !== total_length)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display({"Mismatch on output beat %0d: expected byte %02h last %b ",
                              "term %b len %0d, got byte %02h last %b term %b len %0d"},
                             beats_out, want.data, want.last, want.term, want.len,
                             out_byte, last_of_run, is_terminator, total_length);
            end
        end
    endtask

    // Watch both channels at every rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                stall_cycles++;
            if (in_valid && !in_stall)
            begin
                predict_escape(in_byte, end_of_string);
                beats_in++;
            end
            if (out_valid && !out_stall)
            begin
                compare_beat();
                beats_out++;
                if (is_terminator === 1'b1)
                begin
                    strings_done++;
                    if (total_length === COUNT_CAP)
                        cap_hits++;
                end
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top-level testbench for the XML attribute escaper: clock, reset, stimulus and verdict.
module testbench;
    import xae_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 470;
    localparam int DRAIN_CYCLES = 20;
    localparam int RUN_LIMIT_NS = 60_000_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         in_byte = 8'h00;
    logic               end_of_string = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_byte;
    logic               last_of_run;
    logic               is_terminator;
    logic [COUNT_W-1:0] total_length;

    // Idle controls for the sender and the receiver, set by the stimulus.
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    logic hold_req = 1'b0;

    int fail_count;
    int pending;
    int beats_in;
    int beats_out;
    int strings_done;
    int stall_cycles;
    int cap_hits;

    always #(HALF_PERIOD) clk = ~clk;

    xml_attribute_escaper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .is_terminator (is_terminator),
        .total_length  (total_length)
    );

    xae_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .is_terminator (is_terminator),
        .total_length  (total_length),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_in      (beats_in),
        .beats_out     (beats_out),
        .strings_done  (strings_done),
        .stall_cycles  (stall_cycles),
        .cap_hits      (cap_hits)
    );

    // Offer one source byte after a random gap and wait until it is taken.
    task automatic send_beat(input logic [7:0] b, input logic eos);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_string <= eos;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Draw a text byte, weighted toward the bytes that need escaping.
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = 8'($urandom_range(8'h20, 8'h7e));
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       b = "<";
                    1:       b = "&";
                    2:       b = ">";
                    3:       b = "'";
                    default: b = "\"";
                endcase
            end
            2:       b = 8'($urandom_range(0, 31));
            3:       b = CHAR_DEL;
            4:       b = 8'($urandom_range(128, 255));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Receiver: random stall before each beat, plus one long hold-off on request.
    initial
    begin : receiver
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = rx_quiet ? 0 : $urandom_range(0, 19);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int len;
        int sent;
        int str_idx;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed string: every entity, control bytes, tab and newline, field extremes.
        send_beat("A", 1'b0);
        send_beat("<", 1'b0);
        send_beat("&", 1'b0);
        send_beat(">", 1'b0);
        send_beat("'", 1'b0);
        send_beat("\"", 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CHAR_TAB, 1'b0);
        send_beat(CHAR_LF, 1'b0);
        send_beat(8'h1f, 1'b0);
        send_beat(8'h20, 1'b0);
        send_beat(CHAR_DEL, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(8'h7e, 1'b1);
        // Single-byte strings, including a zero byte as the whole string.
        send_beat("<", 1'b1);
        send_beat(8'h00, 1'b1);
        send_beat(8'h0d, 1'b1);
        send_beat("x", 1'b1);
        send_beat(8'hff, 1'b1);

        // Random strings with random idling; one early string runs against a long hold-off.
        sent = 0;
        str_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (str_idx == 4)
            begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b0;
                hold_req = 1'b1;
                len = 40;
            end
            else
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
            end
            for (int i = 0; i < len; i++)
                send_beat(pick_text_byte(), i == len - 1);
            sent += len;
            str_idx++;
        end
        in_valid <= 1'b0;
        // Let the checker record the last accepted beat before watching the backlog.
        @(posedge clk);

        // Drain, then keep watching so that any stray beats show.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input beats and %0d output beats over %0d strings.",
                 beats_in, beats_out, strings_done);
        $display("Input stalled on %0d cycles; the length counter hit its cap in %0d string(s).",
                 stall_cycles, cap_hits);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
